// File: src/gpc_pkg.sv
// Shared definitions for the Goldbach partition counter.
// Holds result field widths, fixed constants and the controller/datapath
// command and status bundles. No dependencies.
package gpc_pkg;

    localparam int COUNT_W = 16;
    localparam int SMALL_W = 19;
    localparam int LARGE_W = 20;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam int FIRST_PRIME = 2;
    localparam int FIRST_ODD_DIVISOR = 3;
    localparam int MIN_NUMBER = 4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;
        logic load_p;
        logic load_q;
        logic test_init;
        logic div_start;
        logic div_step;
        logic next_div;
        logic record_pair;
        logic next_p;
        logic load_out;
    } gpc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic n_valid;
        logic p_done;
        logic v_lt2;
        logic v_lt4;
        logic v_even;
        logic bound_passed;
        logic div_last;
        logic rem_zero;
    } gpc_sts_t;

endpackage

// File: src/gpc_dp.sv
// Datapath of the Goldbach partition counter: candidate, trial divisor,
// bit-serial remainder unit, pair tally and result registers.
// Depends on gpc_pkg.
module gpc_dp
    import gpc_pkg::*;
#(
    parameter int NUMBER_BITS = 20
)
(
    input  logic                   clk,
    input  logic [NUMBER_BITS-1:0] even_number,
    input  gpc_cmd_t               cmd,
    output gpc_sts_t               sts,
    output logic [COUNT_W-1:0]     pair_count,
    output logic [SMALL_W-1:0]     smaller_prime,
    output logic [LARGE_W-1:0]     larger_prime,
    output logic                   pair_found
);

    localparam int NB    = NUMBER_BITS;
    localparam int SQ_W  = NB + 2;
    localparam int CNT_W = $clog2(NB);

    logic [NB-1:0]      n_reg;
    logic [NB-1:0]      p_reg;
    logic [NB-1:0]      v_reg;
    logic [NB-1:0]      d_reg;
    logic [SQ_W-1:0]    dsq_reg;
    logic [NB-1:0]      rem_reg;
    logic [CNT_W-1:0]   bit_cnt_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [NB-1:0]      small_reg;
    logic [NB-1:0]      large_reg;
    logic               found_reg;

    logic [COUNT_W-1:0] out_count_reg;
    logic [SMALL_W-1:0] out_small_reg;
    logic [LARGE_W-1:0] out_large_reg;
    logic               out_found_reg;

    logic [NB-1:0]          q_value;
    logic [NB:0]            rem_shift;
    logic [NB:0]            rem_diff;
    logic [NB-1:0]          rem_next;
    logic [SMALL_W+NB-1:0]  small_ext;
    logic [LARGE_W+NB-1:0]  large_ext;

    assign q_value   = n_reg - p_reg;
    assign rem_shift = {rem_reg, v_reg[bit_cnt_reg]};
    assign rem_diff  = rem_shift - {1'b0, d_reg};
    // The partial remainder always stays below the divisor, so NB bits hold it.
    assign rem_next  = (rem_shift >= {1'b0, d_reg}) ? rem_diff[NB-1:0] : rem_shift[NB-1:0];
    assign small_ext = {{SMALL_W{1'b0}}, small_reg};
    assign large_ext = {{LARGE_W{1'b0}}, large_reg};

    always_comb
    begin
        sts.n_valid      = (n_reg >= NB'(MIN_NUMBER)) && !n_reg[0];
        sts.p_done       = p_reg > (n_reg >> 1);
        sts.v_lt2        = v_reg < NB'(FIRST_PRIME);
        sts.v_lt4        = v_reg < NB'(MIN_NUMBER);
        sts.v_even       = !v_reg[0];
        sts.bound_passed = dsq_reg > {2'b00, v_reg};
        sts.div_last     = (bit_cnt_reg == '0);
        sts.rem_zero     = (rem_reg == '0);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            n_reg     <= even_number;
            p_reg     <= NB'(FIRST_PRIME);
            count_reg <= '0;
            small_reg <= '0;
            large_reg <= '0;
            found_reg <= 1'b0;
        end
        if (cmd.load_p)
        begin
            v_reg <= p_reg;
        end
        if (cmd.load_q)
        begin
            v_reg <= q_value;
        end
        if (cmd.test_init)
        begin
            d_reg   <= NB'(FIRST_ODD_DIVISOR);
            dsq_reg <= SQ_W'(FIRST_ODD_DIVISOR * FIRST_ODD_DIVISOR);
        end
        if (cmd.div_start)
        begin
            rem_reg     <= '0;
            bit_cnt_reg <= CNT_W'(NB - 1);
        end
        if (cmd.div_step)
        begin
            rem_reg     <= rem_next;
            bit_cnt_reg <= bit_cnt_reg - 1'b1;
        end
        if (cmd.next_div)
        begin
            // (d + 2)^2 = d^2 + 4d + 4
            d_reg   <= d_reg + NB'(2);
            dsq_reg <= dsq_reg + {d_reg, 2'b00} + SQ_W'(4);
        end
        if (cmd.record_pair)
        begin
            if (count_reg != COUNT_MAX)
            begin
                count_reg <= count_reg + 1'b1;
            end
            small_reg <= p_reg;
            large_reg <= q_value;
            found_reg <= 1'b1;
        end
        if (cmd.next_p)
        begin
            p_reg <= p_reg + 1'b1;
        end
        if (cmd.load_out)
        begin
            out_count_reg <= count_reg;
            out_small_reg <= small_ext[SMALL_W-1:0];
            out_large_reg <= large_ext[LARGE_W-1:0];
            out_found_reg <= found_reg;
        end
    end

    assign pair_count    = out_count_reg;
    assign smaller_prime = out_small_reg;
    assign larger_prime  = out_large_reg;
    assign pair_found    = out_found_reg;

endmodule

// File: src/gpc_ctrl.sv
// Controller of the Goldbach partition counter: sequences candidates,
// primality tests and remainder steps, and owns both handshakes.
// Depends on gpc_pkg.
module gpc_ctrl
    import gpc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    output logic     out_valid,
    input  logic     out_stall,
    input  gpc_sts_t sts,
    output gpc_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_P_CHECK,
        ST_CLASSIFY,
        ST_BOUND,
        ST_DIVIDE,
        ST_REM,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   testing_q_reg;
    logic   testing_q_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        logic verdict;
        logic is_prime;

        verdict        = 1'b0;
        is_prime       = 1'b0;
        cmd            = '0;
        state_next     = state_reg;
        testing_q_next = testing_q_reg;
        out_valid_next = out_valid_reg && out_stall;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                state_next = sts.n_valid ? ST_P_CHECK : ST_FINISH;
            end
            ST_P_CHECK:
            begin
                if (sts.p_done)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.load_p     = 1'b1;
                    testing_q_next = 1'b0;
                    state_next     = ST_CLASSIFY;
                end
            end
            ST_CLASSIFY:
            begin
                if (sts.v_lt2)
                begin
                    verdict = 1'b1;
                end
                else if (sts.v_lt4)
                begin
                    verdict  = 1'b1;
                    is_prime = 1'b1;
                end
                else if (sts.v_even)
                begin
                    verdict = 1'b1;
                end
                else
                begin
                    cmd.test_init = 1'b1;
                    state_next    = ST_BOUND;
                end
            end
            ST_BOUND:
            begin
                if (sts.bound_passed)
                begin
                    verdict  = 1'b1;
                    is_prime = 1'b1;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = ST_REM;
                end
            end
            ST_REM:
            begin
                if (sts.rem_zero)
                begin
                    verdict = 1'b1;
                end
                else
                begin
                    cmd.next_div = 1'b1;
                    state_next   = ST_BOUND;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (verdict)
        begin
            if (!testing_q_reg && is_prime)
            begin
                cmd.load_q     = 1'b1;
                testing_q_next = 1'b1;
                state_next     = ST_CLASSIFY;
            end
            else
            begin
                cmd.record_pair = testing_q_reg && is_prime;
                cmd.next_p      = 1'b1;
                state_next      = ST_P_CHECK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            testing_q_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            testing_q_reg <= testing_q_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// File: src/goldbach_partition_counter.sv
// Top level of the Goldbach partition counter: controller plus datapath.
// Depends on gpc_pkg, gpc_ctrl and gpc_dp.
//
//  Channel | Handshake          | Payload
//  --------+--------------------+--------------------------------------------
//  input   | in_valid, in_stall | even_number
//  output  | out_valid, out_stall | pair_count, smaller_prime, larger_prime,
//          |                    | pair_found
//
// One item is worked at a time. Each candidate p from 2 to n/2 is tested, and
// when p is prime its partner n-p is tested too. A tested value that is even
// or below four is settled in the classify state. For an odd value, every
// trial divisor takes a bound check, NUMBER_BITS one-bit remainder steps and
// a remainder check. A value found prime takes one more bound check.
// Besides the divisor work, each candidate takes a candidate check, the
// classify steps and the final bound checks, and each item takes setup, the
// last candidate check and the result load.
// Reset is asynchronous and active low; it clears only control state.
// The finished result sits in an output register, so a new transfer is taken
// as soon as the controller is idle even while out_stall holds the result.
module goldbach_partition_counter
    import gpc_pkg::*;
#(
    parameter int NUMBER_BITS = 20
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [NUMBER_BITS-1:0] even_number,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [COUNT_W-1:0]     pair_count,
    output logic [SMALL_W-1:0]     smaller_prime,
    output logic [LARGE_W-1:0]     larger_prime,
    output logic                   pair_found
);

    gpc_cmd_t cmd;
    gpc_sts_t sts;

    // The controller walks candidates and divisors; the datapath does the
    // arithmetic and reports the compare results it needs.
    gpc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    gpc_dp #(
        .NUMBER_BITS (NUMBER_BITS)
    ) u_dp (
        .clk           (clk),
        .even_number   (even_number),
        .cmd           (cmd),
        .sts           (sts),
        .pair_count    (pair_count),
        .smaller_prime (smaller_prime),
        .larger_prime  (larger_prime),
        .pair_found    (pair_found)
    );

    // A transfer in starts a job, so the block must be busy on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input accepted but controller not busy");

    // The count saturates and never wraps, so it is nonzero exactly when a pair exists.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pair_found == (pair_count != '0)))
        else $error("pair_found disagrees with pair_count");

    // With no pair found, both primes report zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !pair_found) |-> (smaller_prime == '0 && larger_prime == '0))
        else $error("primes reported without a pair");

endmodule

// File: tb/tb.sv
// Self-checking testbench for goldbach_partition_counter: directed table, then random numbers.
// Results come from hand-written table rows or from a trial-division predictor in this file.
// Depends on gpc_pkg and the RTL of goldbach_partition_counter only.
module tb
    import gpc_pkg::*;
();

    localparam int NUMBER_BITS = 20;
    localparam int CLK_HALF = 4;
    localparam int RESET_CYCLES = 12;
    // After the last result the block is idle again; this
    // margin only gives a stray extra result time to show up.
    localparam int SETTLE_CYCLES = 64;
    localparam int NUMBERS_PER_PHASE = 25;
    // This cap is far above the slowest legal run,
    // so only a hung handshake ever reaches it.
    localparam longint RUN_LIMIT = 64'd320_000_000;

    typedef logic [NUMBER_BITS-1:0] number_t;

    // One result transfer, field by field, at the widths of the output ports.
    typedef struct packed {
        logic [COUNT_W-1:0] pair_count;
        logic [SMALL_W-1:0] low_prime;
        logic [LARGE_W-1:0] high_prime;
        logic               pair_found;
    } partition_t;

    // One row of the directed table. When has_answer is set, the result is
    // written into the row by hand; otherwise the predictor supplies it.
    typedef struct {
        number_t    n;
        bit         has_answer;
        partition_t answer;
    } number_row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    number_t    even_number = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [COUNT_W-1:0] pair_count;
    logic [SMALL_W-1:0] smaller_prime;
    logic [LARGE_W-1:0] larger_prime;
    logic       pair_found;

    // Percent chance, per cycle, that the sender idles or the receiver stalls.
    // The main sequence changes these between phases.
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;

    partition_t  pending_partitions[$];
    number_row_t number_table[$];
    int unsigned mismatches = 0;

    goldbach_partition_counter #(
        .NUMBER_BITS(NUMBER_BITS)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .even_number  (even_number),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pair_count   (pair_count),
        .smaller_prime(smaller_prime),
        .larger_prime (larger_prime),
        .pair_found   (pair_found)
    );

    always #(CLK_HALF) clk = ~clk;

    // Primality by trial division. Divisors run while d*d <= v, so perfect
    // squares of odd primes are rejected correctly.
    function automatic bit trial_prime(input int unsigned v);
        int unsigned d;
        if (v < FIRST_PRIME)
        begin
            return 1'b0;
        end
        if (v < MIN_NUMBER)
        begin
            return 1'b1;
        end
        if (v % 2 == 0)
        begin
            return 1'b0;
        end
        for (d = FIRST_ODD_DIVISOR; d * d <= v; d += 2)
        begin
            if (v % d == 0)
            begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // Counts the Goldbach pairs p + q = n with p <= q. The candidates run
    // upward, so the last pair found is the one with the largest p. Odd n and
    // n below four leave every field at zero.
    function automatic partition_t goldbach_split(input number_t n);
        partition_t  r;
        int unsigned p;
        r = '0;
        if (n >= MIN_NUMBER && n[0] == 1'b0)
        begin
            for (p = FIRST_PRIME; p <= n / 2; p++)
            begin
                if (trial_prime(p) && trial_prime(n - p))
                begin
                    if (r.pair_count != COUNT_MAX)
                    begin
                        r.pair_count = r.pair_count + 1'b1;
                    end
                    r.low_prime  = SMALL_W'(p);
                    r.high_prime = LARGE_W'(n - p);
                    r.pair_found = 1'b1;
                end
            end
        end
        return r;
    endfunction

    task automatic add_number(input number_t n, input bit has_answer,
                              input int unsigned cnt, input int unsigned lo,
                              input int unsigned hi, input bit found);
        number_row_t row;
        row.n = n;
        row.has_answer = has_answer;
        row.answer.pair_count = COUNT_W'(cnt);
        row.answer.low_prime  = SMALL_W'(lo);
        row.answer.high_prime = LARGE_W'(hi);
        row.answer.pair_found = found;
        number_table.push_back(row);
    endtask

    // Random stimulus. Most numbers are small even values, the case the block
    // is built for; the cost of an item grows faster than n, so only a tenth
    // are even values above two hundred. The rest is noise: odd values across
    // the full width, which also toggle every upper input bit, and values below four.
    function automatic number_t random_number();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 70)
        begin
            return number_t'(2 * $urandom_range(100, 2));
        end
        if (roll < 80)
        begin
            return number_t'(2 * $urandom_range(250, 101));
        end
        if (roll < 92)
        begin
            return number_t'($urandom) | number_t'(1);
        end
        return number_t'($urandom_range(MIN_NUMBER - 1));
    endfunction

    // Drives one number at a falling edge and holds it until the block takes
    // it. The expected result is queued at the rising edge of the transfer.
    // Each call starts and ends at a falling edge, so in_valid gets a single
    // assignment per falling edge even when transfers run back to back.
    task automatic transfer_number(input number_t n, input partition_t want);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        even_number <= n;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        pending_partitions.push_back(want);
        @(negedge clk);
    endtask

    // The sender holds off until every queued result has been taken.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_partitions.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // The receiver draws a new stall decision at every falling edge, so stalls
    // land on every phase of the block's work, including results that finish right after setup.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic compare_field(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0d got %0d", $time, field, want, got);
            mismatches++;
        end
    endtask

    // Result checker. Every output transfer is matched against the oldest
    // queued expectation; a transfer with nothing queued is a failure too.
    always @(posedge clk)
    begin : check_results
        partition_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_partitions.size() == 0)
            begin
                $display("%0t: result with nothing expected, pair_count %0d",
                         $time, pair_count);
                mismatches++;
            end
            else
            begin
                want = pending_partitions.pop_front();
                compare_field("pair_count", 32'(want.pair_count), 32'(pair_count));
                compare_field("smaller_prime", 32'(want.low_prime),
                              32'(smaller_prime));
                compare_field("larger_prime", 32'(want.high_prime),
                              32'(larger_prime));
                compare_field("pair_found", 32'(want.pair_found), 32'(pair_found));
            end
        end
    end

    initial
    begin : run_limit
        #(RUN_LIMIT);
        $display("status: fail");
        $finish;
    end

    initial
    begin : main_sequence
        int unsigned phase;
        int unsigned k;
        number_t     n;
        int unsigned idle_pcts[4];
        int unsigned stall_pcts[4];

        // Phases: no idling, sender idling, receiver stalling, then both.
        idle_pcts  = '{0, 54, 0, 24};
        stall_pcts = '{0, 0, 54, 24};

        // Numbers below four and odd numbers yield all-zero results.
        add_number(20'd0, 1'b1, 0, 0, 0, 1'b0);
        add_number(20'd1, 1'b1, 0, 0, 0, 1'b0);
        add_number(20'd2, 1'b1, 0, 0, 0, 1'b0);
        add_number(20'd3, 1'b1, 0, 0, 0, 1'b0);
        add_number(20'd5, 1'b1, 0, 0, 0, 1'b0);
        add_number(20'd9, 1'b1, 0, 0, 0, 1'b0);
        add_number(20'hFFFFF, 1'b1, 0, 0, 0, 1'b0);
        add_number(20'hFFFFD, 1'b1, 0, 0, 0, 1'b0);
        add_number(20'h55555, 1'b1, 0, 0, 0, 1'b0);
        add_number(20'hAAAAB, 1'b1, 0, 0, 0, 1'b0);
        // The smallest valid numbers; four is the one case that pairs 2 with 2,
        // and six and ten include a pair with p equal to n/2.
        add_number(20'd4, 1'b1, 1, 2, 2, 1'b1);
        add_number(20'd6, 1'b1, 1, 3, 3, 1'b1);
        add_number(20'd8, 1'b1, 1, 3, 5, 1'b1);
        add_number(20'd10, 1'b1, 2, 5, 5, 1'b1);
        add_number(20'd12, 1'b1, 1, 5, 7, 1'b1);
        // Larger numbers, where squares of odd primes must not pass as primes.
        add_number(20'd14, 1'b0, 0, 0, 0, 1'b0);
        add_number(20'd50, 1'b0, 0, 0, 0, 1'b0);
        add_number(20'd98, 1'b0, 0, 0, 0, 1'b0);
        add_number(20'd128, 1'b0, 0, 0, 0, 1'b0);
        add_number(20'd256, 1'b0, 0, 0, 0, 1'b0);
        add_number(20'd998, 1'b0, 0, 0, 0, 1'b0);
        add_number(20'd2000, 1'b0, 0, 0, 0, 1'b0);

        // Hold reset, then release it at a falling edge.
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (number_table[i])
        begin
            if (number_table[i].has_answer)
            begin
                transfer_number(number_table[i].n, number_table[i].answer);
            end
            else
            begin
                transfer_number(number_table[i].n, goldbach_split(number_table[i].n));
            end
        end

        for (phase = 0; phase < 4; phase++)
        begin
            // Between phases the sender waits until every result has left
            // the block before the idle and stall rates change.
            drain_results();
            send_idle_pct  = idle_pcts[phase];
            recv_stall_pct = stall_pcts[phase];
            for (k = 0; k < NUMBERS_PER_PHASE; k++)
            begin
                n = random_number();
                transfer_number(n, goldbach_split(n));
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (mismatches == 0 && pending_partitions.size() == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
